>>> rtl/fsqg_pkg.sv
// Shared types and constants of the frame statistics quality governor.
`timescale 1ns / 1ps
package fsqg_pkg;
   localparam int NREC      = 9;
   localparam int DIV_NUM_W = 40;
   localparam int DIV_DEN_W = 25;
   localparam int DIV_CNT_W = 6;

   localparam logic [3:0] F_FRAME  = 4'd0;
   localparam logic [3:0] F_SDF    = 4'd1;
   localparam logic [3:0] F_CULL   = 4'd2;
   localparam logic [3:0] F_RAY    = 4'd3;
   localparam logic [3:0] F_TEMP   = 4'd4;
   localparam logic [3:0] F_RECON  = 4'd5;
   localparam logic [3:0] F_STEPS  = 4'd6;
   localparam logic [3:0] F_REPROJ = 4'd7;
   localparam logic [3:0] F_HIT    = 4'd8;

   localparam logic [3:0] OP_REPROJ = 4'd0;
   localparam logic [3:0] OP_STEPS  = 4'd1;
   localparam logic [3:0] OP_HIT    = 4'd2;
   localparam logic [3:0] OP_LAST   = 4'd8;

   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_TARGET = 1'b1;

   localparam logic [15:0] TARGET_RESET = 16'd4267;
   localparam logic [14:0] SCALE_STEP   = 15'd6400;
   localparam logic signed [20:0] TH_FULL    = 21'sd23040;
   localparam logic signed [20:0] TH_THREE_Q = 21'sd16640;
   localparam logic signed [20:0] TH_HALF    = 21'sd10240;

   localparam logic [1:0] LVL_QUARTER = 2'd0;
   localparam logic [1:0] LVL_HALF    = 2'd1;
   localparam logic [1:0] LVL_THREE_Q = 2'd2;
   localparam logic [1:0] LVL_FULL    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATE,
      ST_WRITE,
      ST_WALK,
      ST_MEAN,
      ST_FINISH
   } state_type;

   typedef logic [NREC-1:0][15:0] rec_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [15:0] quot;
   } div_rsp_type;
endpackage

>>> rtl/fsqg_div.sv
// Restoring bit-serial divider with saturated 16-bit quotient.
`timescale 1ns / 1ps
module fsqg_div (
   input  logic                 clock,
   input  logic                 reset,
   input  fsqg_pkg::div_req_type req,
   output fsqg_pkg::div_rsp_type rsp
);
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic                           zero_ff, zero_in;
   logic [fsqg_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [fsqg_pkg::DIV_NUM_W-1:0] acc_ff, acc_in;
   logic [fsqg_pkg::DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [fsqg_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [fsqg_pkg::DIV_DEN_W:0]   shifted;
   logic [fsqg_pkg::DIV_DEN_W:0]   diff;
   logic                           ge;

   always_comb begin
      shifted = {rem_ff, acc_ff[fsqg_pkg::DIV_NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (busy_ff) begin
         acc_in = {acc_ff[fsqg_pkg::DIV_NUM_W-2:0], ge};
         rem_in = ge ? diff[fsqg_pkg::DIV_DEN_W-1:0] : shifted[fsqg_pkg::DIV_DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == fsqg_pkg::DIV_CNT_W'(fsqg_pkg::DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         zero_in = req.den == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   always_comb begin
      rsp.busy = busy_ff;
      rsp.done = done_ff;
      if (zero_ff) begin
         rsp.quot = '0;
      end else if (|acc_ff[fsqg_pkg::DIV_NUM_W-1:16]) begin
         rsp.quot = 16'hFFFF;
      end else begin
         rsp.quot = acc_ff[15:0];
      end
   end
endmodule

>>> rtl/fsqg_hist_mem.sv
// History ring memory of per-frame records.
`timescale 1ns / 1ps
module fsqg_hist_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  fsqg_pkg::rec_type  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output fsqg_pkg::rec_type  rd_data
);
   fsqg_pkg::rec_type mem [DEPTH];
   fsqg_pkg::rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/frame_stats_quality_governor.sv
// Frame statistics and adaptive quality governor, top level.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  frame timings and counts, 242 bits
//   rsp      out  rsp_tvalid/rsp_tready  frame index, nine means, level
//   csr      in   csr_we                 csr_index, csr_wdata
//
// An item runs three rate divisions, one memory read a cycle over its n valid
// history frames and nine mean divisions; all twelve share the serial divider.
// The block takes no item while one is at work; a finished result waits in the
// output register and the block returns to idle once it is loaded there.
// Reset is synchronous; the history memory needs no clearing pass.
`timescale 1ns / 1ps
module frame_stats_quality_governor #(
   parameter int HISTORY_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // frame_time, culling_time, raymarch_time, temporal_time, reconstruct_time,
   // total_pixels, reprojected_pixels, traced_pixels, ray_steps, cache_hits,
   // cache_misses, cached_instances
   input  logic [247:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // frame_index, mean_frame_time, mean_sdf_time, mean_culling_time,
   // mean_raymarch_time, mean_temporal_time, mean_reconstruct_time,
   // mean_steps_per_ray, mean_reproject_rate, mean_hit_rate, quality_level
   output logic [183:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);
   localparam int SLOT_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = 16 + $clog2(HISTORY_DEPTH);

   fsqg_pkg::state_type state_ff, state_in;
   logic [3:0]              op_ff, op_in;
   logic                    issued_ff, issued_in;
   fsqg_pkg::rec_type       rec_ff, rec_in;
   fsqg_pkg::rec_type       means_ff, means_in;
   logic [21:0]             total_ff, total_in, reproj_ff, reproj_in, traced_ff, traced_in;
   logic [31:0]             steps_ff, steps_in;
   logic [23:0]             hits_ff, hits_in, misses_ff, misses_in;
   logic                    nocache_ff, nocache_in;
   logic [31:0]             fc_ff, fc_in, idx_ff, idx_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [CNT_W-1:0]        n_ff, n_in, walk_ff, walk_in;
   logic                    pend_ff, pend_in;
   logic [fsqg_pkg::NREC-1:0][SUM_W-1:0] sums_ff, sums_in;
   logic signed [16:0]      err_ff, err_in;
   logic [1:0]              level_ff, level_in;
   logic                    enable_ff, enable_in;
   logic [15:0]             target_ff, target_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [183:0]            rsp_data_ff, rsp_data_in;

   fsqg_pkg::div_req_type   div_req;
   fsqg_pkg::div_rsp_type   div_rsp;
   logic                    mem_we;
   fsqg_pkg::rec_type       mem_rd;
   logic                    accept, load_out;
   logic [17:0]             sdf_sum;
   logic [24:0]             hm_sum;
   logic [2:0]              lvl_p1;
   logic [14:0]             scale;
   logic signed [16:0]      err_new;
   logic signed [20:0]      err_ext, s_val;
   logic [1:0]              level_new;

   fsqg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   fsqg_hist_mem #(
      .DEPTH (HISTORY_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (slot_ff),
      .wr_data (rec_ff),
      .rd_addr (walk_ff[SLOT_W-1:0]),
      .rd_data (mem_rd)
   );

   assign accept   = req_tvalid && req_tready;
   assign load_out = (state_ff == fsqg_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsqg_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = fsqg_pkg::ST_RATE;
         end
         fsqg_pkg::ST_RATE: begin
            if (div_rsp.done && op_ff == fsqg_pkg::OP_HIT) state_in = fsqg_pkg::ST_WRITE;
         end
         fsqg_pkg::ST_WRITE: begin
            state_in = fsqg_pkg::ST_WALK;
         end
         fsqg_pkg::ST_WALK: begin
            if (walk_ff == n_ff && !pend_ff) state_in = fsqg_pkg::ST_MEAN;
         end
         fsqg_pkg::ST_MEAN: begin
            if (div_rsp.done && op_ff == fsqg_pkg::OP_LAST) state_in = fsqg_pkg::ST_FINISH;
         end
         fsqg_pkg::ST_FINISH: begin
            if (load_out) state_in = fsqg_pkg::ST_IDLE;
         end
         default: state_in = fsqg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      mem_we        = 1'b0;
      hm_sum        = {1'b0, hits_ff} + {1'b0, misses_ff};
      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.den   = '0;
      case (state_ff)
         fsqg_pkg::ST_IDLE:  req_tready = 1'b1;
         fsqg_pkg::ST_WRITE: mem_we = 1'b1;
         fsqg_pkg::ST_RATE: begin
            div_req.start = !issued_ff;
            case (op_ff)
               fsqg_pkg::OP_REPROJ: begin
                  div_req.num = {2'b0, reproj_ff, 16'b0};
                  div_req.den = {3'b0, total_ff};
               end
               fsqg_pkg::OP_STEPS: begin
                  div_req.num = {steps_ff, 8'b0};
                  div_req.den = {3'b0, traced_ff};
               end
               default: begin
                  div_req.num = {hits_ff, 16'b0};
                  div_req.den = nocache_ff ? '0 : hm_sum;
               end
            endcase
         end
         fsqg_pkg::ST_MEAN: begin
            div_req.start = !issued_ff;
            div_req.num   = fsqg_pkg::DIV_NUM_W'(sums_ff[op_ff]);
            div_req.den   = fsqg_pkg::DIV_DEN_W'(n_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      lvl_p1    = {1'b0, level_ff} + 3'd1;
      scale     = 15'(lvl_p1 * fsqg_pkg::SCALE_STEP);
      err_new   = $signed({1'b0, target_ff}) - $signed({1'b0, rec_ff[fsqg_pkg::F_FRAME]});
      err_ext   = {{4{err_new[16]}}, err_new};
      s_val     = $signed({6'b0, scale}) + err_ext + (err_ext <<< 1)
                  - $signed({{4{err_ff[16]}}, err_ff});
      if (s_val > fsqg_pkg::TH_FULL) level_new = fsqg_pkg::LVL_FULL;
      else if (s_val > fsqg_pkg::TH_THREE_Q) level_new = fsqg_pkg::LVL_THREE_Q;
      else if (s_val > fsqg_pkg::TH_HALF) level_new = fsqg_pkg::LVL_HALF;
      else level_new = fsqg_pkg::LVL_QUARTER;
   end

   always_comb begin
      op_in        = op_ff;
      issued_in    = issued_ff;
      rec_in       = rec_ff;
      means_in     = means_ff;
      total_in     = total_ff;
      reproj_in    = reproj_ff;
      traced_in    = traced_ff;
      steps_in     = steps_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      nocache_in   = nocache_ff;
      fc_in        = fc_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      n_in         = n_ff;
      walk_in      = walk_ff;
      pend_in      = 1'b0;
      sums_in      = sums_ff;
      err_in       = err_ff;
      level_in     = level_ff;
      enable_in    = enable_ff;
      target_in    = target_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      sdf_sum      = {2'b0, req_tdata[31:16]} + {2'b0, req_tdata[47:32]}
                     + {2'b0, req_tdata[63:48]} + {2'b0, req_tdata[79:64]};

      if (csr_we) begin
         case (csr_index)
            fsqg_pkg::CSR_ENABLE: enable_in = csr_wdata[0];
            default:              target_in = csr_wdata;
         endcase
      end

      if (div_req.start) issued_in = 1'b1;

      case (state_ff)
         fsqg_pkg::ST_IDLE: begin
            if (accept) begin
               rec_in[fsqg_pkg::F_FRAME] = req_tdata[15:0];
               rec_in[fsqg_pkg::F_CULL]  = req_tdata[31:16];
               rec_in[fsqg_pkg::F_RAY]   = req_tdata[47:32];
               rec_in[fsqg_pkg::F_TEMP]  = req_tdata[63:48];
               rec_in[fsqg_pkg::F_RECON] = req_tdata[79:64];
               rec_in[fsqg_pkg::F_SDF]   = (|sdf_sum[17:16]) ? 16'hFFFF : sdf_sum[15:0];
               total_in   = req_tdata[101:80];
               reproj_in  = req_tdata[123:102];
               traced_in  = req_tdata[145:124];
               steps_in   = req_tdata[177:146];
               hits_in    = req_tdata[201:178];
               misses_in  = req_tdata[225:202];
               nocache_in = req_tdata[241:226] == 16'd0;
               idx_in     = fc_ff;
               op_in      = '0;
               issued_in  = 1'b0;
            end
         end
         fsqg_pkg::ST_RATE: begin
            if (div_rsp.done) begin
               case (op_ff)
                  fsqg_pkg::OP_REPROJ: rec_in[fsqg_pkg::F_REPROJ] = div_rsp.quot;
                  fsqg_pkg::OP_STEPS:  rec_in[fsqg_pkg::F_STEPS]  = div_rsp.quot;
                  default:             rec_in[fsqg_pkg::F_HIT]    = div_rsp.quot;
               endcase
               op_in     = (op_ff == fsqg_pkg::OP_HIT) ? 4'd0 : op_ff + 4'd1;
               issued_in = 1'b0;
            end
         end
         fsqg_pkg::ST_WRITE: begin
            fc_in   = fc_ff + 32'd1;
            slot_in = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
            if (fc_in == 32'd0 || fc_in >= 32'(HISTORY_DEPTH)) begin
               n_in = CNT_W'(HISTORY_DEPTH);
            end else begin
               n_in = fc_in[CNT_W-1:0];
            end
            walk_in = '0;
            sums_in = '0;
         end
         fsqg_pkg::ST_WALK: begin
            if (walk_ff != n_ff) begin
               walk_in = walk_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               for (int j = 0; j < fsqg_pkg::NREC; j++) begin
                  sums_in[j] = sums_ff[j] + SUM_W'(mem_rd[j]);
               end
            end
         end
         fsqg_pkg::ST_MEAN: begin
            if (div_rsp.done) begin
               means_in[op_ff] = div_rsp.quot;
               op_in           = (op_ff == fsqg_pkg::OP_LAST) ? 4'd0 : op_ff + 4'd1;
               issued_in       = 1'b0;
            end
         end
         fsqg_pkg::ST_FINISH: begin
            if (load_out) begin
               if (enable_ff) begin
                  level_in = level_new;
                  err_in   = err_new;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, (enable_ff ? level_new : level_ff), means_ff, idx_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsqg_pkg::ST_IDLE;
         issued_ff    <= 1'b0;
         op_ff        <= '0;
         fc_ff        <= '0;
         slot_ff      <= '0;
         pend_ff      <= 1'b0;
         walk_ff      <= '0;
         n_ff         <= '0;
         err_ff       <= '0;
         level_ff     <= fsqg_pkg::LVL_FULL;
         enable_ff    <= 1'b0;
         target_ff    <= fsqg_pkg::TARGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         op_ff        <= op_in;
         fc_ff        <= fc_in;
         slot_ff      <= slot_in;
         pend_ff      <= pend_in;
         walk_ff      <= walk_in;
         n_ff         <= n_in;
         err_ff       <= err_in;
         level_ff     <= level_in;
         enable_ff    <= enable_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rec_ff      <= rec_in;
      means_ff    <= means_in;
      total_ff    <= total_in;
      reproj_ff   <= reproj_in;
      traced_ff   <= traced_in;
      steps_ff    <= steps_in;
      hits_ff     <= hits_in;
      misses_ff   <= misses_in;
      nocache_ff  <= nocache_in;
      idx_ff      <= idx_in;
      sums_ff     <= sums_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");
   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> issued_ff)
      else $error("divider result without request");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fsqg_pkg::ST_WALK) |-> (walk_ff <= n_ff && n_ff != '0))
      else $error("history walk out of range");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid_ff)
      else $error("result not presented");
endmodule

>>> sim/frame_stats_checker.sv
// Checker for the frame statistics quality governor: predicts and compares each result.
`timescale 1ns / 1ps
module frame_stats_checker #(
   parameter int HISTORY_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [247:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [183:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata,
   output int           fail_count,
   output int           pending_count,
   output int           frame_count_seen,
   output int           level_changes
);
   logic        enable_reg;
   logic [15:0] target_reg;
   logic [15:0] history [HISTORY_DEPTH][fsqg_pkg::NREC];
   int          slot;
   logic [31:0] frames_done;
   int          last_err;
   logic [1:0]  level;
   logic [183:0] expected_q [$];
   string       field_name [11] = '{"frame_index", "mean_frame_time", "mean_sdf_time",
                                    "mean_culling_time", "mean_raymarch_time",
                                    "mean_temporal_time", "mean_reconstruct_time",
                                    "mean_steps_per_ray", "mean_reproject_rate",
                                    "mean_hit_rate", "quality_level"};

   function automatic logic [15:0] clip16(longint unsigned v);
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic logic [183:0] predict_frame(logic [247:0] d);
      logic [15:0]     r [fsqg_pkg::NREC];
      longint unsigned sums [fsqg_pkg::NREC];
      longint unsigned total, reproj, traced, steps, hits, misses, cached;
      logic [183:0]    o;
      int              n, e, s;
      logic [1:0]      new_level;
      r[fsqg_pkg::F_FRAME] = d[15:0];
      r[fsqg_pkg::F_CULL]  = d[31:16];
      r[fsqg_pkg::F_RAY]   = d[47:32];
      r[fsqg_pkg::F_TEMP]  = d[63:48];
      r[fsqg_pkg::F_RECON] = d[79:64];
      total  = d[101:80];
      reproj = d[123:102];
      traced = d[145:124];
      steps  = d[177:146];
      hits   = d[201:178];
      misses = d[225:202];
      cached = d[241:226];
      r[fsqg_pkg::F_SDF] = clip16(longint'(r[fsqg_pkg::F_CULL]) + r[fsqg_pkg::F_RAY]
                                  + r[fsqg_pkg::F_TEMP] + r[fsqg_pkg::F_RECON]);
      r[fsqg_pkg::F_REPROJ] = (total == 0) ? 16'd0 : clip16((reproj << 16) / total);
      r[fsqg_pkg::F_STEPS] = (steps == 0 || traced == 0) ? 16'd0
                             : clip16((steps << 8) / traced);
      r[fsqg_pkg::F_HIT] = (cached == 0 || hits + misses == 0) ? 16'd0
                           : clip16((hits << 16) / (hits + misses));
      o = '0;
      o[31:0] = frames_done;
      frames_done = frames_done + 1;
      for (int j = 0; j < fsqg_pkg::NREC; j++) history[slot][j] = r[j];
      slot = (slot + 1) % HISTORY_DEPTH;
      n = (frames_done < HISTORY_DEPTH) ? int'(frames_done) : HISTORY_DEPTH;
      if (n == 0) n = HISTORY_DEPTH;
      for (int j = 0; j < fsqg_pkg::NREC; j++) begin
         sums[j] = 0;
         for (int i = 0; i < n; i++) sums[j] += history[i][j];
         o[32 + 16*j +: 16] = sums[j] / n;
      end
      if (enable_reg) begin
         e = int'(target_reg) - int'(r[fsqg_pkg::F_FRAME]);
         s = 6400 * (int'(level) + 1) + 3 * e - last_err;
         if (s > 23040) new_level = fsqg_pkg::LVL_FULL;
         else if (s > 16640) new_level = fsqg_pkg::LVL_THREE_Q;
         else if (s > 10240) new_level = fsqg_pkg::LVL_HALF;
         else new_level = fsqg_pkg::LVL_QUARTER;
         if (new_level != level) level_changes++;
         level = new_level;
         last_err = e;
      end
      o[177:176] = level;
      return o;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [183:0] want;
      if (reset) begin
         enable_reg = 1'b0;
         target_reg = fsqg_pkg::TARGET_RESET;
         slot = 0;
         frames_done = '0;
         last_err = 0;
         level = fsqg_pkg::LVL_FULL;
         expected_q.delete();
         fail_count = 0;
         pending_count <= 0;
         frame_count_seen <= 0;
         level_changes = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == fsqg_pkg::CSR_ENABLE) enable_reg = csr_wdata[0];
            else target_reg = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            expected_q.push_back(predict_frame(req_tdata));
            frame_count_seen <= frame_count_seen + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected item, index", rsp_tdata[31:0], 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[31:0] != want[31:0])
                  report_mismatch(field_name[0], rsp_tdata[31:0], want[31:0]);
               for (int j = 0; j < fsqg_pkg::NREC; j++)
                  if (rsp_tdata[32 + 16*j +: 16] != want[32 + 16*j +: 16])
                     report_mismatch(field_name[j + 1], rsp_tdata[32 + 16*j +: 16],
                                     want[32 + 16*j +: 16]);
               if (rsp_tdata[177:176] != want[177:176])
                  report_mismatch(field_name[10], rsp_tdata[177:176], want[177:176]);
            end
         end
         pending_count <= expected_q.size();
      end
   end
endmodule

>>> sim/testbench.sv
// Top of the frame statistics quality governor testbench: stimulus, idling and verdict.
`timescale 1ns / 1ps
module testbench;
   localparam int LIMIT = 3000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [247:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [183:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic         csr_index = fsqg_pkg::CSR_ENABLE;
   logic [15:0]  csr_wdata = '0;
   int           fail_count, pending_count, frames_seen, level_changes;
   int           cycle_count = 0;
   int           stall_left = 0;
   logic         stalls_on = 1'b1;
   logic [15:0]  target_now = fsqg_pkg::TARGET_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   frame_stats_quality_governor #(.HISTORY_DEPTH(64)) dut (.*);

   frame_stats_checker #(.HISTORY_DEPTH(64)) u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .rsp_tvalid, .rsp_tready,
      .rsp_tdata, .csr_we, .csr_index, .csr_wdata, .fail_count, .pending_count,
      .frame_count_seen(frames_seen), .level_changes
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
         stall_left <= gap_len();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [247:0] make_frame(
      logic [15:0] ft, logic [15:0] cull, logic [15:0] ray, logic [15:0] temp,
      logic [15:0] recon, logic [21:0] total, logic [21:0] reproj, logic [21:0] traced,
      logic [31:0] steps, logic [23:0] hits, logic [23:0] misses, logic [15:0] cached);
      return {6'd0, cached, misses, hits, steps, traced, reproj, total,
              recon, temp, ray, cull, ft};
   endfunction

   function automatic logic [247:0] random_frame();
      logic [21:0] total;
      int          ft;
      if ($urandom_range(0, 3) == 0)
         return {6'd0, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, 18'($urandom)}};
      total = $urandom_range(0, 9) == 0 ? 22'd0 : 22'($urandom_range(1, 4194303));
      ft = int'(target_now) + int'($urandom_range(0, 4000)) - 2000;
      if (ft < 0) ft = 0;
      if (ft > 65535) ft = 65535;
      return make_frame(16'(ft), 16'($urandom_range(0, 2000)), 16'($urandom_range(0, 9000)),
                        16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)), total,
                        22'($urandom_range(0, total)), 22'($urandom_range(0, 4194303)),
                        $urandom_range(0, 9) == 0 ? 32'd0 : $urandom,
                        24'($urandom_range(0, 16777215)),
                        24'($urandom_range(0, 16777215)),
                        $urandom_range(0, 7) == 0 ? 16'd0 : 16'($urandom));
   endfunction

   task automatic send_frame(logic [247:0] d);
      repeat (1 + gap_len()) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= d;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_reg(logic idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_mode(logic en, logic [15:0] target);
      drain();
      write_reg(fsqg_pkg::CSR_ENABLE, {15'($urandom_range(0, 32767)), en});
      write_reg(fsqg_pkg::CSR_TARGET, target);
      target_now = target;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_frame(make_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_frame('1);
      send_frame(make_frame('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
      send_frame(make_frame(1000, 100, 200, 300, 400, 0, 500, 100, 5000, 10, 10, 1));
      send_frame(make_frame(1000, 100, 200, 300, 400, 1000, 2000, 0, 5000, 10, 10, 1));
      send_frame(make_frame(1000, 100, 200, 300, 400, 1000, 500, 100, 0, 10, 10, 1));
      send_frame(make_frame(1000, 100, 200, 300, 400, 1000, 500, 1, 32'hFFFFFFFF, 0, 0, 7));
      send_frame(make_frame(1000, 100, 200, 300, 400, 1000, 1000, 1, 65535, 5, 0, 0));
      send_frame(make_frame(1000, 40000, 30000, 1, 1, 4194303, 1, 4194303, 1, 1, 16777215, 3));

      set_mode(1'b1, fsqg_pkg::TARGET_RESET);
      send_frame(make_frame(0, 10, 10, 10, 10, 100, 50, 100, 800, 9, 1, 1));
      send_frame(make_frame(16'hFFFF, 10, 10, 10, 10, 100, 50, 100, 800, 9, 1, 1));
      send_frame(make_frame(16'hFFFF, 10, 10, 10, 10, 100, 50, 100, 800, 9, 1, 1));
      send_frame(make_frame(8000, 10, 10, 10, 10, 100, 50, 100, 800, 9, 1, 1));
      send_frame(make_frame(4267, 10, 10, 10, 10, 100, 50, 100, 800, 9, 1, 1));
      send_frame(make_frame(0, 10, 10, 10, 10, 100, 50, 100, 800, 9, 1, 1));
      send_frame(make_frame(0, 10, 10, 10, 10, 100, 50, 100, 800, 9, 1, 1));
      for (int i = 0; i < 130; i++) send_frame(random_frame());

      set_mode(1'b1, 16'd0);
      for (int i = 0; i < 130; i++) send_frame(random_frame());
      set_mode(1'b1, 16'hFFFF);
      stalls_on = 1'b0;
      for (int i = 0; i < 130; i++) send_frame(random_frame());
      stalls_on = 1'b1;
      set_mode(1'b1, 16'($urandom));
      for (int i = 0; i < 130; i++) send_frame(random_frame());
      set_mode(1'b0, 16'($urandom));
      for (int i = 0; i < 130; i++) send_frame(random_frame());
      set_mode(1'b1, fsqg_pkg::TARGET_RESET);
      for (int i = 0; i < 130; i++) send_frame(random_frame());

      drain();
      repeat (700) @(posedge clock);
      $display("Covered %0d frames over seven register settings, history wrap included.",
               frames_seen);
      $display("Controller changed the quality level %0d times.", level_changes);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

>>> frame_stats_quality_governor.f
rtl/fsqg_pkg.sv
rtl/fsqg_div.sv
rtl/fsqg_hist_mem.sv
rtl/frame_stats_quality_governor.sv
sim/frame_stats_checker.sv
sim/testbench.sv
